// ===== rtl/lje_pkg.sv =====
// Shared types and constants for the Lennard-Jones pair energy pipeline.
// No dependencies; used by lje_divider and lennard_jones_pair_energy_top.
package lje_pkg;

  localparam int COORD_W   = 32;
  localparam int R2_W      = 35;
  localparam int Q_W       = 32;
  localparam int NUM_LO_W  = 16;
  localparam int CFG_IDX_W = 8;

  // Cutoff of 2.5 in Q16.16 and its square with 32 fraction bits.
  localparam logic [COORD_W:0] CUT_RAW  = 33'd163840;
  localparam logic [R2_W+1:0]  CUT2_Q32 = 37'd26843545600;

  // Negated energy shift, 4*(2.5^-12 - 2.5^-6) rounded in Q16.16.
  localparam logic [51:0] U_SHIFT_ADD = 52'd1069;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WELL_DEPTH = 8'd0,
    CFG_ZERO_CROSS = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_a_x;
    logic signed [COORD_W-1:0] pos_a_y;
    logic signed [COORD_W-1:0] pos_a_z;
    logic signed [COORD_W-1:0] pos_b_x;
    logic signed [COORD_W-1:0] pos_b_y;
    logic signed [COORD_W-1:0] pos_b_z;
  } lje_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pair_energy;
    logic                      within_cutoff;
    logic                      saturated;
  } lje_out_t;

  // Status that travels with an item beside the arithmetic payload.
  typedef struct packed {
    logic in_range;
    logic sat;
  } lje_side_t;

endpackage

// ===== rtl/lje_divider.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on lje_pkg for widths and the side status struct.
module lje_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [lje_pkg::R2_W-1:0]      in_r2,
  input  logic [lje_pkg::R2_W-1:0]      in_rem,
  input  lje_pkg::lje_side_t            in_side,
  input  logic [lje_pkg::NUM_LO_W-1:0]  num_lo,
  output logic                          out_valid,
  output logic [lje_pkg::Q_W-1:0]       out_quo,
  output lje_pkg::lje_side_t            out_side
);
  import lje_pkg::*;

  logic              valid_q [0:Q_W-1];
  logic [R2_W-1:0]   rem_q   [0:Q_W-1];
  logic [R2_W-1:0]   r2_q    [0:Q_W-1];
  logic [Q_W-1:0]    quo_q   [0:Q_W-1];
  lje_side_t         side_q  [0:Q_W-1];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic            src_valid;
    logic [R2_W-1:0] src_rem;
    logic [R2_W-1:0] src_r2;
    logic [Q_W-1:0]  src_quo;
    lje_side_t       src_side;
    logic            bit_in;
    logic [R2_W:0]   trial;
    logic [R2_W:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_rem;
      assign src_r2    = in_r2;
      assign src_quo   = '0;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_rem   = rem_q[k-1];
      assign src_r2    = r2_q[k-1];
      assign src_quo   = quo_q[k-1];
      assign src_side  = side_q[k-1];
    end

    // The low dividend bits are the low 16 bits of sigma squared, then zeros.
    if (k < NUM_LO_W) begin : g_data
      assign bit_in = num_lo[NUM_LO_W-1-k];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {src_rem, bit_in};
    assign diff  = trial - {1'b0, src_r2};
    assign ge    = trial >= {1'b0, src_r2};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[k] <= 1'b0;
      end else if (en) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[R2_W-1:0] : trial[R2_W-1:0];
        r2_q[k]   <= src_r2;
        quo_q[k]  <= {src_quo[Q_W-2:0], ge};
        side_q[k] <= src_side;
      end
    end
  end

  assign out_valid = valid_q[Q_W-1];
  assign out_quo   = quo_q[Q_W-1];
  assign out_side  = side_q[Q_W-1];

endmodule

// ===== rtl/lennard_jones_pair_energy_top.sv =====
// Top level of the truncated, shifted Lennard-Jones pair energy pipeline.
// Depends on lje_pkg and instantiates lje_divider.

// This block takes one request per cycle while in_ready is high, each a pair
// of particle positions in signed Q16.16, and returns one result per request
// in the same order. Five stages form the squared distance and the cutoff
// test, thirty-two stages of the divider produce one bit each of sigma^2/r2,
// six stages form the powers and the epsilon scaling, and one output register
// holds the result. Every stage holds one request, so the sustained rate is
// one request per cycle while the output keeps up. A skid register behind the
// output lets one more result arrive while the output waits, and in_ready
// falls only while that skid register is occupied, so the whole pipeline
// freezes together without losing or repeating a request. The configuration
// registers well_depth (index 0) and zero_crossing_distance (index 1) are
// written through the cfg channel, which is always ready; writes to other
// indexes are ignored. Configuration must only be written while no request
// is in flight.
module lennard_jones_pair_energy_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lje_pkg::lje_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lje_pkg::lje_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lje_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import lje_pkg::*;

  localparam logic signed [51:0] E_MAX = 52'sd2147483647;
  localparam logic signed [51:0] E_MIN = -52'sd2147483648;

  // A Q16.16 product shifted back down, clamped at the unsigned 32-bit limit.
  // The top bit of the result flags the clamp.
  function automatic logic [32:0] clamp_q(input logic [63:0] prod);
    logic [32:0] res;
    if (prod[63:48] != 16'd0) begin
      res = {1'b1, 32'hFFFF_FFFF};
    end else begin
      res = {1'b0, prod[47:16]};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. The cfg channel never stalls.
  // ---------------------------------------------------------------------------
  logic [31:0] well_depth;
  logic [31:0] zero_crossing_distance;
  logic [63:0] sig_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      well_depth             <= 32'd65536;
      zero_crossing_distance <= 32'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WELL_DEPTH: well_depth             <= cfg_data;
        CFG_ZERO_CROSS: zero_crossing_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sigma squared is recomputed every cycle. It is first needed by the stage 5
  // divider setup, well after any configuration write has settled.
  always_ff @(posedge clk) begin
    sig_sq <= zero_crossing_distance * zero_crossing_distance;
  end

  // ---------------------------------------------------------------------------
  // Global advance. The pipeline moves whenever the skid register is empty.
  // ---------------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: exact 33-bit coordinate differences.
  // ---------------------------------------------------------------------------
  logic                   v1;
  logic signed [COORD_W:0] d1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= {in_data.pos_a_x[COORD_W-1], in_data.pos_a_x}
             - {in_data.pos_b_x[COORD_W-1], in_data.pos_b_x};
      d1[1] <= {in_data.pos_a_y[COORD_W-1], in_data.pos_a_y}
             - {in_data.pos_b_y[COORD_W-1], in_data.pos_b_y};
      d1[2] <= {in_data.pos_a_z[COORD_W-1], in_data.pos_a_z}
             - {in_data.pos_b_z[COORD_W-1], in_data.pos_b_z};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitudes and the per-axis cutoff test. A magnitude below the
  // cutoff fits in 18 bits, so only those bits go on.
  // ---------------------------------------------------------------------------
  logic        v2;
  logic        far2;
  logic [17:0] m2 [0:2];
  logic [COORD_W:0] mag1 [0:2];
  logic [2:0]  far_axis;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1[i]     = d1[i][COORD_W] ? (COORD_W+1)'(0) - d1[i] : d1[i];
      far_axis[i] = mag1[i] >= CUT_RAW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far2 <= |far_axis;
      for (int i = 0; i < 3; i++) begin
        m2[i] <= mag1[i][17:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squares of the three magnitudes.
  // ---------------------------------------------------------------------------
  logic        v3;
  logic        far3;
  logic [35:0] sq3 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far3 <= far2;
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= m2[i] * m2[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: squared distance r2 with 32 fraction bits.
  // ---------------------------------------------------------------------------
  logic            v4;
  logic            far4;
  logic [R2_W+1:0] r2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      far4 <= far3;
      r2_4 <= {1'b0, sq3[0]} + {1'b0, sq3[1]} + {1'b0, sq3[2]};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: final cutoff decision and divider setup. The quotient
  // sigma^2 * 2^16 / r2 overflows 32 bits exactly when sigma^2 >= r2 * 2^16;
  // otherwise the upper dividend bits are already below r2 and seed the
  // partial remainder.
  // ---------------------------------------------------------------------------
  logic            v5;
  lje_side_t       side5;
  logic [R2_W-1:0] r2_5;
  logic [R2_W-1:0] rem5;
  logic            out_range4;
  logic            div_over4;

  assign out_range4 = far4 || (r2_4 == '0) || (r2_4 >= CUT2_Q32);
  assign div_over4  = sig_sq >= {11'd0, r2_4, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5.in_range <= !out_range4;
      side5.sat      <= div_over4;
      r2_5           <= r2_4[R2_W-1:0];
      rem5           <= sig_sq[R2_W+15:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: s2 = floor(sigma^2 * 2^16 / r2), one bit per stage.
  // ---------------------------------------------------------------------------
  logic            vd;
  logic [Q_W-1:0]  quo_d;
  lje_side_t       side_d;

  lje_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_r2     (r2_5),
    .in_rem    (rem5),
    .in_side   (side5),
    .num_lo    (sig_sq[NUM_LO_W-1:0]),
    .out_valid (vd),
    .out_quo   (quo_d),
    .out_side  (side_d)
  );

  // ---------------------------------------------------------------------------
  // M1: s2 (saturated on divider overflow) and s2*s2.
  // ---------------------------------------------------------------------------
  logic        vm1;
  lje_side_t   side_m1;
  logic [31:0] s2_m1;
  logic [63:0] p_m1;
  logic [31:0] s2_d;

  assign s2_d = side_d.sat ? 32'hFFFF_FFFF : quo_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (en) begin
      vm1 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m1 <= side_d;
      s2_m1   <= s2_d;
      p_m1    <= s2_d * s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // M2: s4 = clamp(s2*s2) and s4*s2.
  // ---------------------------------------------------------------------------
  logic        vm2;
  lje_side_t   side_m2;
  logic [63:0] p_m2;
  logic [32:0] s4_c;

  assign s4_c = clamp_q(p_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (en) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m2.in_range <= side_m1.in_range;
      side_m2.sat      <= side_m1.sat | s4_c[32];
      p_m2             <= s4_c[31:0] * s2_m1;
    end
  end

  // ---------------------------------------------------------------------------
  // M3: s6 = clamp(s4*s2) and s6*s6.
  // ---------------------------------------------------------------------------
  logic        vm3;
  lje_side_t   side_m3;
  logic [31:0] s6_m3;
  logic [63:0] p_m3;
  logic [32:0] s6_c;

  assign s6_c = clamp_q(p_m2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm3 <= 1'b0;
    end else if (en) begin
      vm3 <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m3.in_range <= side_m2.in_range;
      side_m3.sat      <= side_m2.sat | s6_c[32];
      s6_m3            <= s6_c[31:0];
      p_m3             <= s6_c[31:0] * s6_c[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // M4: s12 = clamp(s6*s6) and the exact signed difference s12 - s6.
  // ---------------------------------------------------------------------------
  logic               vm4;
  lje_side_t          side_m4;
  logic signed [32:0] diff_m4;
  logic [32:0]        s12_c;

  assign s12_c = clamp_q(p_m3);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm4 <= 1'b0;
    end else if (en) begin
      vm4 <= vm3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m4.in_range <= side_m3.in_range;
      side_m4.sat      <= side_m3.sat | s12_c[32];
      diff_m4          <= {1'b0, s12_c[31:0]} - {1'b0, s6_m3};
    end
  end

  // ---------------------------------------------------------------------------
  // M5: sign and magnitude of the difference.
  // ---------------------------------------------------------------------------
  logic        vm5;
  lje_side_t   side_m5;
  logic        neg_m5;
  logic [31:0] abs_m5;
  logic [32:0] abs_full;

  assign abs_full = diff_m4[32] ? 33'd0 - diff_m4 : diff_m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm5 <= 1'b0;
    end else if (en) begin
      vm5 <= vm4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m5 <= side_m4;
      neg_m5  <= diff_m4[32];
      abs_m5  <= abs_full[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // M6: epsilon times the magnitude of the difference.
  // ---------------------------------------------------------------------------
  logic        vm6;
  lje_side_t   side_m6;
  logic        neg_m6;
  logic [63:0] p_m6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm6 <= 1'b0;
    end else if (en) begin
      vm6 <= vm5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_m6 <= side_m5;
      neg_m6  <= neg_m5;
      p_m6    <= well_depth * abs_m5;
    end
  end

  // ---------------------------------------------------------------------------
  // Final stage: scale by four (shift of 14 instead of 16), restore the sign
  // so the result rounds toward zero, remove the shift and saturate to int32.
  // Items outside the cutoff come out as all zeros.
  // ---------------------------------------------------------------------------
  logic [49:0]        mag_f;
  logic signed [51:0] u_f;
  logic [31:0]        energy_f;
  logic               clip_f;
  lje_out_t           result_f;

  always_comb begin
    mag_f = p_m6[63:14];
    if (neg_m6) begin
      u_f = $signed(U_SHIFT_ADD - {2'b00, mag_f});
    end else begin
      u_f = $signed({2'b00, mag_f} + U_SHIFT_ADD);
    end
    if (u_f > E_MAX) begin
      energy_f = 32'h7FFF_FFFF;
      clip_f   = 1'b1;
    end else if (u_f < E_MIN) begin
      energy_f = 32'h8000_0000;
      clip_f   = 1'b1;
    end else begin
      energy_f = u_f[31:0];
      clip_f   = 1'b0;
    end
    result_f.pair_energy   = side_m6.in_range ? energy_f : 32'd0;
    result_f.within_cutoff = side_m6.in_range;
    result_f.saturated     = side_m6.in_range & (side_m6.sat | clip_f);
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry. When the output holds a result that
  // is not taken, a result arriving from the pipeline parks in the skid entry,
  // which then freezes the pipeline until the output drains.
  // ---------------------------------------------------------------------------
  lje_out_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (en && vm6) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= en && vm6;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (en && vm6) begin
        skid_data <= result_f;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (en && vm6) begin
      out_data <= result_f;
    end
  end

endmodule
